/* rtl/core/assert_macros.svh */
// Assertion helpers included by the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCOT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rcot: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RCOT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rcot: next-cycle check failed");

`endif

/* rtl/core/rcot_pkg.sv */
package rcot_pkg;

    // Action codes carried in the request word.
    localparam logic [2:0] ACT_GET        = 3'd0;
    localparam logic [2:0] ACT_REF        = 3'd1;
    localparam logic [2:0] ACT_UNREF      = 3'd2;
    localparam logic [2:0] ACT_TOUCH      = 3'd3;
    localparam logic [2:0] ACT_DROP_MOUNT = 3'd4;

    // Status codes carried in the result word.
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_NO_ENTRY = 2'd2;

    // Request word.
    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  mount_id;
        logic [63:0] object_key;
        logic [7:0]  slot_index;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  result_slot;
        logic        was_hit;
        logic        did_evict;
        logic        entry_freed;
        logic [63:0] inode_number;
        logic [15:0] ref_count_after;
        logic [8:0]  dropped_count;
    } t_out_word;

    // Sequencer states.
    typedef enum logic [2:0] {
        SQ_CLEAR,
        SQ_IDLE,
        SQ_SCAN,
        SQ_SCAN_END,
        SQ_SLOT_MOD,
        SQ_DONE
    } t_seq_state;

endpackage

/* rtl/core/refcounted_object_cache_table_unit.sv */
// Reference-counted object cache table. Slot actions (add reference, drop
// reference, mark dirty) make one read and at most one write-back on the entry
// memory between the accepted word and the result. Get and drop-mount walk every
// entry through the single read port of that memory before the next word is
// taken. After reset the table is cleared one entry per cycle, and no word is
// accepted until every entry has been cleared. A finished result sits in an output
// register, so the next word may be accepted while the previous result is still
// stalled.
`include "assert_macros.svh"

module refcounted_object_cache_table_unit #(
    parameter int ENTRIES  = 256,
    parameter int REF_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rcot_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rcot_pkg::t_out_word o_out_word
);

    import rcot_pkg::*;

    localparam int CW = $clog2(ENTRIES + 1);

    logic                in_ready;
    logic                res_valid;
    logic                res_take;
    t_out_word           res_word;
    logic [CW-1:0]       occupied;
    logic                r_out_valid;
    t_out_word           r_out_word;

    rcot_engine #(
        .ENTRIES  (ENTRIES),
        .REF_BITS (REF_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (i_in_word),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res_word  (res_word),
        .o_occupied  (occupied)
    );

    assign o_in_stall = !in_ready;

    // Output register: loads a result when empty or being drained.
    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_word <= res_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // An accepted word always leaves the sequencer busy in the next cycle.
    `RCOT_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    // No new word is taken while a result waits in the sequencer.
    `RCOT_ASSERT_IMP(a_stall_with_result, i_clk, i_rst_n, res_valid, o_in_stall)
    // The occupancy count never runs past the size of the table.
    `RCOT_ASSERT_IMP(a_occ_bounded, i_clk, i_rst_n, 1'b1, occupied <= CW'(ENTRIES))

endmodule

/* rtl/core/rcot_mem.sv */
module rcot_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 85
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/rcot_engine.sv */
module rcot_engine #(
    parameter int ENTRIES  = 256,
    parameter int REF_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  rcot_pkg::t_in_word           i_in_word,
    output logic                         o_res_valid,
    input  logic                         i_res_take,
    output rcot_pkg::t_out_word          o_res_word,
    output logic [$clog2(ENTRIES+1)-1:0] o_occupied
);

    import rcot_pkg::*;

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int EW = REF_BITS + 69;
    localparam logic [AW-1:0]       LAST    = AW'(ENTRIES - 1);
    localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};
    localparam logic [REF_BITS-1:0] REF_ONE = REF_BITS'(1);
    localparam logic [REF_BITS-1:0] REF_NEW = REF_BITS'(2);
    localparam logic [31:0]         ENTRIES_W = 32'(ENTRIES);

    typedef struct packed {
        logic                valid;
        logic [2:0]          mount;
        logic [63:0]         key;
        logic [REF_BITS-1:0] refs;
        logic                dirty;
    } t_entry;

    // Sequencer and datapath registers.
    t_seq_state          r_state, n_state;
    t_in_word            r_req, n_req;
    logic [AW-1:0]       r_slot_addr, n_slot_addr;
    logic [AW-1:0]       r_idx, n_idx;
    logic                r_issue_on, n_issue_on;
    logic                r_chk_on, n_chk_on;
    logic [AW-1:0]       r_chk_idx, n_chk_idx;
    logic                r_hit, n_hit;
    logic [AW-1:0]       r_hit_idx, n_hit_idx;
    logic [REF_BITS-1:0] r_hit_refs, n_hit_refs;
    logic                r_hit_dirty, n_hit_dirty;
    logic                r_free_on, n_free_on;
    logic [AW-1:0]       r_free_idx, n_free_idx;
    logic                r_evict_on, n_evict_on;
    logic [AW-1:0]       r_evict_idx, n_evict_idx;
    logic [CW-1:0]       r_drop_n, n_drop_n;
    logic [CW-1:0]       r_occ, n_occ;
    t_out_word           r_res, n_res;

    // Memory port signals.
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_entry;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [EW-1:0] rd_data;
    t_entry        rd_entry;

    // Decoded request and entry conditions.
    logic          accept;
    logic          in_range;
    logic [AW+7:0] slot_wide;
    logic          is_slot_act;
    logic          get_match;
    logic          drop_match;
    logic          evictable;

    function automatic logic [7:0] to_slot(input logic [AW-1:0] idx);
        logic [AW+7:0] w;
        w = {8'b0, idx};
        return w[7:0];
    endfunction

    function automatic logic [15:0] to_count(input logic [REF_BITS-1:0] r);
        logic [REF_BITS+15:0] w;
        w = {16'b0, r};
        return w[15:0];
    endfunction

    function automatic logic [8:0] to_dropped(input logic [CW-1:0] n);
        logic [CW+8:0] w;
        w = {9'b0, n};
        return w[8:0];
    endfunction

    function automatic logic [63:0] to_inode(input logic [63:0] key);
        return (key == 64'd0) ? 64'd1 : key;
    endfunction

    function automatic logic [REF_BITS-1:0] ref_inc(input logic [REF_BITS-1:0] r);
        return (r == REF_MAX) ? REF_MAX : r + REF_ONE;
    endfunction

    function automatic t_out_word blank_word(input logic [1:0] status,
                                             input logic [7:0] slot);
        t_out_word w;
        w                 = '0;
        w.status          = status;
        w.result_slot     = slot;
        w.inode_number    = 64'd1;
        return w;
    endfunction

    rcot_mem #(
        .DEPTH (ENTRIES),
        .WIDTH (EW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_entry),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_entry    = t_entry'(rd_data);
    assign o_in_ready  = (r_state == SQ_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign slot_wide   = {{AW{1'b0}}, i_in_word.slot_index};
    assign in_range    = {24'b0, i_in_word.slot_index} < ENTRIES_W;
    assign is_slot_act = (i_in_word.action == ACT_REF) || (i_in_word.action == ACT_UNREF)
                      || (i_in_word.action == ACT_TOUCH);
    assign get_match   = rd_entry.valid && (rd_entry.mount == r_req.mount_id)
                      && (rd_entry.key == r_req.object_key);
    assign drop_match  = rd_entry.valid && (rd_entry.mount == r_req.mount_id);
    assign evictable   = rd_entry.valid && (rd_entry.refs == REF_ONE) && !rd_entry.dirty;

    assign o_res_valid = (r_state == SQ_DONE);
    assign o_res_word  = r_res;
    assign o_occupied  = r_occ;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SQ_CLEAR: begin
                if (r_idx == LAST) begin
                    n_state = SQ_IDLE;
                end
            end
            SQ_IDLE: begin
                if (accept) begin
                    if ((i_in_word.action == ACT_GET) || (i_in_word.action == ACT_DROP_MOUNT)) begin
                        n_state = SQ_SCAN;
                    end else if (is_slot_act && in_range) begin
                        n_state = SQ_SLOT_MOD;
                    end else begin
                        n_state = SQ_DONE;
                    end
                end
            end
            SQ_SCAN: begin
                if (r_chk_on && (r_chk_idx == LAST)) begin
                    n_state = SQ_SCAN_END;
                end
            end
            SQ_SCAN_END: n_state = SQ_DONE;
            SQ_SLOT_MOD: n_state = SQ_DONE;
            SQ_DONE: begin
                if (i_res_take) begin
                    n_state = SQ_IDLE;
                end
            end
            default: n_state = SQ_IDLE;
        endcase
    end

    // Memory accesses and datapath updates for each state.
    always_comb begin
        n_req       = r_req;
        n_slot_addr = r_slot_addr;
        n_idx       = r_idx;
        n_issue_on  = r_issue_on;
        n_chk_on    = 1'b0;
        n_chk_idx   = r_chk_idx;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_hit_refs  = r_hit_refs;
        n_hit_dirty = r_hit_dirty;
        n_free_on   = r_free_on;
        n_free_idx  = r_free_idx;
        n_evict_on  = r_evict_on;
        n_evict_idx = r_evict_idx;
        n_drop_n    = r_drop_n;
        n_occ       = r_occ;
        n_res       = r_res;
        wr_en       = 1'b0;
        wr_addr     = r_chk_idx;
        wr_entry    = rd_entry;
        rd_en       = 1'b0;
        rd_addr     = r_idx;

        unique case (r_state)
            // Clearing pass over the table after reset.
            SQ_CLEAR: begin
                wr_en    = 1'b1;
                wr_addr  = r_idx;
                wr_entry = '0;
                n_idx    = (r_idx == LAST) ? '0 : r_idx + 1'b1;
            end

            // Take a request; in-range slot actions start their read at once.
            SQ_IDLE: begin
                if (accept) begin
                    n_req       = i_in_word;
                    n_slot_addr = slot_wide[AW-1:0];
                    n_idx       = '0;
                    n_issue_on  = 1'b1;
                    n_hit       = 1'b0;
                    n_free_on   = 1'b0;
                    n_evict_on  = 1'b0;
                    n_drop_n    = '0;
                    if (is_slot_act) begin
                        if (in_range) begin
                            rd_en   = 1'b1;
                            rd_addr = slot_wide[AW-1:0];
                        end else begin
                            n_res = blank_word(STAT_NO_ENTRY, i_in_word.slot_index);
                        end
                    end else if (i_in_word.action != ACT_GET
                                 && i_in_word.action != ACT_DROP_MOUNT) begin
                        n_res = blank_word(STAT_OK, 8'd0);
                    end
                end
            end

            // Walk the table: reads run one entry ahead of the checks.
            SQ_SCAN: begin
                rd_en     = r_issue_on;
                rd_addr   = r_idx;
                n_chk_on  = r_issue_on;
                n_chk_idx = r_idx;
                if (r_issue_on) begin
                    n_idx = r_idx + 1'b1;
                    if (r_idx == LAST) begin
                        n_issue_on = 1'b0;
                    end
                end
                if (r_chk_on) begin
                    if (r_req.action == ACT_DROP_MOUNT) begin
                        if (drop_match) begin
                            wr_en          = 1'b1;
                            wr_addr        = r_chk_idx;
                            wr_entry       = rd_entry;
                            wr_entry.valid = 1'b0;
                            n_drop_n       = r_drop_n + 1'b1;
                        end
                    end else begin
                        if (get_match) begin
                            n_hit       = 1'b1;
                            n_hit_idx   = r_chk_idx;
                            n_hit_refs  = rd_entry.refs;
                            n_hit_dirty = rd_entry.dirty;
                        end
                        if (!rd_entry.valid && !r_free_on) begin
                            n_free_on  = 1'b1;
                            n_free_idx = r_chk_idx;
                        end
                        if (evictable && !r_evict_on) begin
                            n_evict_on  = 1'b1;
                            n_evict_idx = r_chk_idx;
                        end
                    end
                end
            end

            // Settle the outcome of the walk and write back at most one entry.
            SQ_SCAN_END: begin
                wr_entry.valid = 1'b1;
                wr_entry.mount = r_req.mount_id;
                wr_entry.key   = r_req.object_key;
                wr_entry.refs  = REF_NEW;
                wr_entry.dirty = 1'b0;
                if (r_req.action == ACT_DROP_MOUNT) begin
                    n_occ               = r_occ - r_drop_n;
                    n_res               = blank_word(STAT_OK, 8'd0);
                    n_res.dropped_count = to_dropped(r_drop_n);
                end else if (r_hit) begin
                    wr_en                 = 1'b1;
                    wr_addr               = r_hit_idx;
                    wr_entry.refs         = ref_inc(r_hit_refs);
                    wr_entry.dirty        = r_hit_dirty;
                    n_res                 = blank_word(STAT_OK, to_slot(r_hit_idx));
                    n_res.was_hit         = 1'b1;
                    n_res.inode_number    = to_inode(r_req.object_key);
                    n_res.ref_count_after = to_count(ref_inc(r_hit_refs));
                end else if (r_free_on || r_evict_on) begin
                    wr_en   = 1'b1;
                    wr_addr = r_free_on ? r_free_idx : r_evict_idx;
                    if (r_free_on) begin
                        n_occ = r_occ + 1'b1;
                    end
                    n_res                 = blank_word(STAT_OK, to_slot(wr_addr));
                    n_res.did_evict       = !r_free_on;
                    n_res.inode_number    = to_inode(r_req.object_key);
                    n_res.ref_count_after = to_count(REF_NEW);
                end else begin
                    n_res = blank_word(STAT_FULL, 8'd0);
                end
            end

            // Read-modify-write of the one addressed slot.
            SQ_SLOT_MOD: begin
                wr_addr = r_slot_addr;
                if (!rd_entry.valid) begin
                    n_res = blank_word(STAT_NO_ENTRY, r_req.slot_index);
                end else begin
                    n_res                 = blank_word(STAT_OK, r_req.slot_index);
                    n_res.inode_number    = to_inode(rd_entry.key);
                    n_res.ref_count_after = to_count(rd_entry.refs);
                    unique case (r_req.action) inside
                        ACT_REF: begin
                            wr_en                 = 1'b1;
                            wr_entry.refs         = ref_inc(rd_entry.refs);
                            n_res.ref_count_after = to_count(ref_inc(rd_entry.refs));
                        end
                        ACT_UNREF: begin
                            if (rd_entry.refs != '0) begin
                                wr_en                 = 1'b1;
                                wr_entry.refs         = rd_entry.refs - REF_ONE;
                                n_res.ref_count_after = to_count(rd_entry.refs - REF_ONE);
                                if (rd_entry.refs == REF_ONE) begin
                                    wr_entry.valid    = 1'b0;
                                    n_occ             = r_occ - 1'b1;
                                    n_res.entry_freed = 1'b1;
                                end
                            end
                        end
                        default: begin
                            wr_en          = 1'b1;
                            wr_entry.dirty = 1'b1;
                        end
                    endcase
                end
            end

            SQ_DONE: begin
            end

            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= SQ_CLEAR;
            r_idx      <= '0;
            r_issue_on <= 1'b0;
            r_chk_on   <= 1'b0;
            r_occ      <= '0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_issue_on <= n_issue_on;
            r_chk_on   <= n_chk_on;
            r_occ      <= n_occ;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_slot_addr <= n_slot_addr;
        r_chk_idx   <= n_chk_idx;
        r_hit       <= n_hit;
        r_hit_idx   <= n_hit_idx;
        r_hit_refs  <= n_hit_refs;
        r_hit_dirty <= n_hit_dirty;
        r_free_on   <= n_free_on;
        r_free_idx  <= n_free_idx;
        r_evict_on  <= n_evict_on;
        r_evict_idx <= n_evict_idx;
        r_drop_n    <= n_drop_n;
        r_res       <= n_res;
    end

endmodule

/* verif/refcounted_object_cache_table_unit_test.sv */
module refcounted_object_cache_table_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rcot_pkg::*;

    localparam int ENTRIES     = 256;
    localparam int REF_BITS    = 16;
    localparam int CLK_PERIOD  = 8;
    localparam int HOLD_CYCLES = 600;
    localparam int QUIET_LIMIT = 4000;
    localparam int PRINT_LIMIT = 40;
    localparam int POOL_KEYS   = 12;
    localparam int TAIL_CYCLES = ENTRIES + 44;
    localparam int PILE_REFS   = 8;

    localparam logic [REF_BITS-1:0] REF_MAX = '1;

    // Action codes that the block does not define.
    localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;

    refcounted_object_cache_table_unit #(
        .ENTRIES  (ENTRIES),
        .REF_BITS (REF_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Shadow copy of the cache table.
    bit                  cache_valid [ENTRIES];
    bit [2:0]            cache_mount [ENTRIES];
    bit [63:0]           cache_key   [ENTRIES];
    bit [REF_BITS-1:0]   cache_refs  [ENTRIES];
    bit                  cache_dirty [ENTRIES];
    int                  cache_occupied = 0;

    t_out_word   queued_replies [$];
    t_out_word   oldest_reply;
    t_out_word   last_reply;
    int          bad_words    = 0;
    int          quiet_cycles = 0;
    int          send_pct     = 0;
    int          recv_pct     = 0;
    bit          hold_req     = 1'b0;
    int          hold_left    = 0;
    logic [63:0] key_pool [POOL_KEYS];

    function automatic logic [REF_BITS-1:0] ref_bump(input logic [REF_BITS-1:0] r);
        return (r == REF_MAX) ? r : r + 1'b1;
    endfunction

    // Fills the entry part of a reply from the shadow table.
    function automatic t_out_word entry_view(input t_out_word base, input int s);
        t_out_word r;
        r = base;
        r.result_slot     = 8'(s);
        r.inode_number    = (cache_key[s] == '0) ? 64'd1 : cache_key[s];
        r.ref_count_after = 16'(cache_refs[s]);
        return r;
    endfunction

    // Applies one action to the shadow table and returns the reply it causes.
    function automatic t_out_word cache_apply(input t_in_word w);
        t_out_word r;
        int        found;
        bit        evict;
        int        n;
        r = '0;
        r.inode_number = 64'd1;
        found = -1;
        evict = 1'b0;
        n = 0;
        case (w.action)
            ACT_GET: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (found < 0 && cache_valid[i] && cache_mount[i] == w.mount_id &&
                        cache_key[i] == w.object_key) begin
                        found = i;
                    end
                end
                if (found >= 0) begin
                    cache_refs[found] = ref_bump(cache_refs[found]);
                    r.was_hit = 1'b1;
                    r = entry_view(r, found);
                end else begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (found < 0 && !cache_valid[i]) begin
                            found = i;
                        end
                    end
                    // A full table may reuse the lowest clean entry held only by the cache.
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (found < 0 && cache_valid[i] && cache_refs[i] == 1 && !cache_dirty[i]) begin
                            found = i;
                            evict = 1'b1;
                        end
                    end
                    if (found < 0) begin
                        r.status = STAT_FULL;
                    end else begin
                        cache_valid[found] = 1'b1;
                        cache_mount[found] = w.mount_id;
                        cache_key[found]   = w.object_key;
                        cache_refs[found]  = REF_BITS'(2);
                        cache_dirty[found] = 1'b0;
                        if (!evict) begin
                            cache_occupied++;
                        end
                        r.did_evict = evict;
                        r = entry_view(r, found);
                    end
                end
            end
            ACT_REF, ACT_UNREF, ACT_TOUCH: begin
                r.result_slot = w.slot_index;
                if (!cache_valid[w.slot_index]) begin
                    r.status = STAT_NO_ENTRY;
                end else begin
                    if (w.action == ACT_REF) begin
                        cache_refs[w.slot_index] = ref_bump(cache_refs[w.slot_index]);
                    end else if (w.action == ACT_UNREF) begin
                        if (cache_refs[w.slot_index] != 0) begin
                            cache_refs[w.slot_index]--;
                            if (cache_refs[w.slot_index] == 0) begin
                                cache_valid[w.slot_index] = 1'b0;
                                cache_occupied--;
                                r.entry_freed = 1'b1;
                            end
                        end
                    end else begin
                        cache_dirty[w.slot_index] = 1'b1;
                    end
                    r = entry_view(r, w.slot_index);
                end
            end
            ACT_DROP_MOUNT: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (cache_valid[i] && cache_mount[i] == w.mount_id) begin
                        cache_valid[i] = 1'b0;
                        n++;
                    end
                end
                cache_occupied -= n;
                r.dropped_count = 9'(n);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic t_in_word make_word(input logic [2:0] act, input logic [2:0] mnt,
                                           input logic [63:0] key, input logic [7:0] slot);
        t_in_word w;
        w.action     = act;
        w.mount_id   = mnt;
        w.object_key = key;
        w.slot_index = slot;
        return w;
    endfunction

    function automatic logic [63:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    // Picks a slot that holds an entry, starting the search at a random place.
    function automatic logic [7:0] pick_live_slot();
        int start;
        start = $urandom_range(ENTRIES - 1);
        for (int k = 0; k < ENTRIES; k++) begin
            if (cache_valid[(start + k) % ENTRIES]) begin
                return 8'((start + k) % ENTRIES);
            end
        end
        return 8'(start);
    endfunction

    // Offers one word from a falling edge and returns at the falling edge after it is taken.
    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < send_pct) begin
            @(negedge i_clk);
        end
        i_in_word  = w;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) begin
            @(posedge i_clk);
        end
        last_reply = cache_apply(w);
        queued_replies.push_back(last_reply);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // Holds the sender back until every reply has arrived.
    task automatic drain_replies();
        while (queued_replies.size() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic set_idle_rates(input int sender, input int receiver);
        @(posedge i_clk);
        send_pct = sender;
        recv_pct = receiver;
        @(negedge i_clk);
    endtask

    // Field extremes, every action and the corner cases on a near-empty table.
    task automatic test_directed();
        send_word(make_word(ACT_GET, 3'd0, 64'd0, 8'($urandom)));
        send_word(make_word(ACT_GET, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 8'($urandom)));
        send_word(make_word(ACT_GET, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 8'($urandom)));
        send_word(make_word(ACT_GET, 3'd3, 64'd0, 8'($urandom)));
        send_word(make_word(ACT_REF, 3'($urandom), rand_key(), 8'd1));
        send_word(make_word(ACT_TOUCH, 3'($urandom), rand_key(), 8'd0));
        // Two drops on a fresh entry free it; the key of zero reads back as one.
        send_word(make_word(ACT_UNREF, 3'($urandom), rand_key(), 8'd2));
        send_word(make_word(ACT_UNREF, 3'($urandom), rand_key(), 8'd2));
        // Slot actions on empty slots change nothing.
        send_word(make_word(ACT_REF, 3'($urandom), rand_key(), 8'd2));
        send_word(make_word(ACT_UNREF, 3'($urandom), rand_key(), 8'd2));
        send_word(make_word(ACT_TOUCH, 3'($urandom), rand_key(), 8'd2));
        send_word(make_word(ACT_REF, 3'($urandom), rand_key(), 8'd255));
        send_word(make_word(ACT_GET, 3'd5, 64'h0123_4567_89AB_CDEF, 8'd255));
        send_word(make_word(ACT_DROP_MOUNT, 3'd6, rand_key(), 8'($urandom)));
        send_word(make_word(ACT_DROP_MOUNT, 3'd7, rand_key(), 8'($urandom)));
        for (int a = ACT_UNUSED_FIRST; a <= ACT_UNUSED_LAST; a++) begin
            send_word(make_word(3'(a), 3'($urandom), rand_key(), 8'($urandom)));
        end
        send_word(make_word(ACT_DROP_MOUNT, 3'd0, 64'd0, 8'd0));
        send_word(make_word(ACT_DROP_MOUNT, 3'd3, 64'hFFFF_FFFF_FFFF_FFFF, 8'd255));
        send_word(make_word(ACT_DROP_MOUNT, 3'd5, rand_key(), 8'($urandom)));
        drain_replies();
    endtask

    // Fills the whole table from one mount, then works the full and eviction paths.
    task automatic test_fill_and_evict();
        logic [2:0]  m;
        logic [31:0] tag;
        int          n;
        m   = 3'($urandom);
        tag = $urandom;
        n   = 0;
        while (cache_occupied < ENTRIES) begin
            send_word(make_word(ACT_GET, m, {tag, 24'($urandom), 8'(n)}, 8'($urandom)));
            n++;
        end
        // Every entry holds two references: nothing can be evicted.
        send_word(make_word(ACT_GET, m, rand_key(), 8'($urandom)));
        send_word(make_word(ACT_UNREF, 3'($urandom), rand_key(), 8'd10));
        send_word(make_word(ACT_GET, 3'($urandom), rand_key(), 8'($urandom)));
        // A dirty entry is passed over in favour of a higher clean one.
        send_word(make_word(ACT_UNREF, 3'($urandom), rand_key(), 8'd5));
        send_word(make_word(ACT_TOUCH, 3'($urandom), rand_key(), 8'd5));
        send_word(make_word(ACT_UNREF, 3'($urandom), rand_key(), 8'd20));
        send_word(make_word(ACT_GET, 3'($urandom), rand_key(), 8'($urandom)));
        send_word(make_word(ACT_GET, 3'($urandom), rand_key(), 8'($urandom)));
        send_word(make_word(ACT_UNREF, 3'($urandom), rand_key(), 8'd5));
        send_word(make_word(ACT_GET, m, rand_key(), 8'($urandom)));
        for (int k = 0; k < 8; k++) begin
            send_word(make_word(ACT_DROP_MOUNT, 3'(k), rand_key(), 8'($urandom)));
        end
        drain_replies();
    endtask

    // The receiver holds off for a long stretch while words keep coming.
    task automatic test_backpressure();
        @(posedge i_clk);
        hold_req = 1'b1;
        @(negedge i_clk);
        for (int k = 0; k < 5; k++) begin
            send_word(make_word(ACT_GET, 3'($urandom), rand_key(), 8'($urandom)));
            send_word(make_word(ACT_REF, 3'($urandom), rand_key(), pick_live_slot()));
        end
        drain_replies();
    endtask

    // Mostly well-formed traffic on a small key set, with some noise.
    task automatic test_random_traffic(input int items);
        int          pick;
        logic [7:0]  slot;
        logic [63:0] key;
        for (int n = 0; n < items; n++) begin
            pick = $urandom_range(99);
            slot = ($urandom_range(99) < 80) ? pick_live_slot() : 8'($urandom);
            key  = ($urandom_range(9) == 0) ? rand_key() : key_pool[$urandom_range(POOL_KEYS - 1)];
            if (pick < 40) begin
                send_word(make_word(ACT_GET, 3'($urandom), key, 8'($urandom)));
            end else if (pick < 60) begin
                send_word(make_word(ACT_REF, 3'($urandom), rand_key(), slot));
            end else if (pick < 80) begin
                send_word(make_word(ACT_UNREF, 3'($urandom), rand_key(), slot));
            end else if (pick < 92) begin
                send_word(make_word(ACT_TOUCH, 3'($urandom), rand_key(), slot));
            end else if (pick < 96) begin
                send_word(make_word(ACT_DROP_MOUNT, 3'($urandom), rand_key(), 8'($urandom)));
            end else begin
                send_word(make_word(3'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST)),
                                    3'($urandom), rand_key(), 8'($urandom)));
            end
        end
        drain_replies();
    endtask

    // Stacks references onto one entry, then mixes in a get hit, a drop and a re-add.
    task automatic test_ref_pileup();
        logic [2:0]  m;
        logic [63:0] key;
        logic [7:0]  s;
        m   = 3'($urandom);
        key = rand_key();
        send_word(make_word(ACT_GET, m, key, 8'($urandom)));
        s = last_reply.result_slot;
        if (last_reply.status == STAT_OK) begin
            repeat (PILE_REFS) begin
                send_word(make_word(ACT_REF, 3'($urandom), rand_key(), s));
            end
            send_word(make_word(ACT_GET, m, key, 8'($urandom)));
            send_word(make_word(ACT_UNREF, 3'($urandom), rand_key(), s));
            send_word(make_word(ACT_REF, 3'($urandom), rand_key(), s));
        end
        send_word(make_word(ACT_DROP_MOUNT, m, rand_key(), 8'($urandom)));
        drain_replies();
    endtask

    // Receiver stall: a long hold-off when asked, otherwise random at the set rate.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_pct);
        end
    end

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (got !== want) begin
            bad_words++;
            if (bad_words <= PRINT_LIMIT) begin
                $display("%0t ns: %s mismatch: expected %h, actual %h", $time, name, want, got);
            end
        end
    endtask

    // Each accepted result word is compared with the oldest outstanding reply.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (queued_replies.size() == 0) begin
                bad_words++;
                if (bad_words <= PRINT_LIMIT) begin
                    $display("%0t ns: stray result word: expected none, actual %p", $time, o_out_word);
                end
            end else begin
                oldest_reply = queued_replies.pop_front();
                check_field("status", oldest_reply.status, o_out_word.status);
                check_field("result_slot", oldest_reply.result_slot, o_out_word.result_slot);
                check_field("was_hit", oldest_reply.was_hit, o_out_word.was_hit);
                check_field("did_evict", oldest_reply.did_evict, o_out_word.did_evict);
                check_field("entry_freed", oldest_reply.entry_freed, o_out_word.entry_freed);
                check_field("inode_number", oldest_reply.inode_number, o_out_word.inode_number);
                check_field("ref_count_after", oldest_reply.ref_count_after,
                            o_out_word.ref_count_after);
                check_field("dropped_count", oldest_reply.dropped_count, o_out_word.dropped_count);
            end
        end
    end

    // Ends the run when no word moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && i_out_stall === 1'b0)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t ns: no word moved for %0d cycles", $time, QUIET_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        key_pool[0] = 64'd0;
        key_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
        for (int k = 2; k < POOL_KEYS; k++) begin
            key_pool[k] = rand_key();
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        set_idle_rates(33, 86);
        test_directed();
        test_fill_and_evict();
        test_random_traffic(245);
        set_idle_rates(86, 33);
        test_random_traffic(245);
        set_idle_rates(0, 0);
        test_random_traffic(245);
        test_backpressure();
        test_ref_pileup();

        // Let any late or stray word show itself before the verdict.
        drain_replies();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (bad_words == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
